/* sv/p3at_pkg.sv */
// ----------------------------------------------------------------------------
// p3at_pkg
// Shared types, register indexes, angle constants and helper functions of
// the 3D point affine transform.
// ----------------------------------------------------------------------------
package p3at_pkg;

  // default parameter values
  localparam int FRAC_BITS_DEF = 16;
  localparam int NEAR_TOL_DEF  = 1;

  // angle and trig precision
  localparam int ANG_FRAC     = 24;
  localparam int TRIG_FRAC    = 30;
  localparam int CORDIC_STEPS = 24;

  // transform kinds
  localparam logic [1:0] MODE_MOVE   = 2'd0;
  localparam logic [1:0] MODE_SCALE  = 2'd1;
  localparam logic [1:0] MODE_ROTATE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_CENTER_X = 3'd1;
  localparam logic [2:0] REG_CENTER_Y = 3'd2;
  localparam logic [2:0] REG_CENTER_Z = 3'd3;
  localparam logic [2:0] REG_COEFF_X  = 3'd4;
  localparam logic [2:0] REG_COEFF_Y  = 3'd5;
  localparam logic [2:0] REG_COEFF_Z  = 3'd6;

  // turn fractions in degrees with ANG_FRAC fraction bits
  localparam logic [33:0] FULL_TURN    = 34'd6039797760;
  localparam logic [33:0] HALF_TURN    = 34'd3019898880;
  localparam logic [33:0] QUARTER_TURN = 34'd1509949440;

  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] trig_t;

  typedef struct packed {
    logic valid;
    logic skip;
  } p3at_ctl_t;

  // atan(2^-i) in degrees, ANG_FRAC fraction bits
  function automatic logic signed [33:0] atan_deg(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // clamp to the signed 32-bit range
  function automatic coord_t sat32(input logic signed [67:0] v);
    coord_t r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/p3at_plane.sv */
// ----------------------------------------------------------------------------
// p3at_plane
// One plane rotation about a center point: difference, four trig products,
// rounded sum with saturation. Three register stages, one point per cycle.
// ----------------------------------------------------------------------------
module p3at_plane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  p3at_pkg::p3at_ctl_t  ctl_i,
  input  p3at_pkg::coord_t     a_i,
  input  p3at_pkg::coord_t     b_i,
  input  p3at_pkg::coord_t     c_i,
  input  p3at_pkg::coord_t     ca_i,
  input  p3at_pkg::coord_t     cb_i,
  input  p3at_pkg::trig_t      sn_i,
  input  p3at_pkg::trig_t      cs_i,
  output p3at_pkg::p3at_ctl_t  ctl_o,
  output p3at_pkg::coord_t     a_o,
  output p3at_pkg::coord_t     b_o,
  output p3at_pkg::coord_t     c_o
);
  import p3at_pkg::*;

  localparam int PW = 66;
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (TRIG_FRAC - 1);

  p3at_ctl_t          ctl1_r, ctl2_r, ctl3_r;
  coord_t             a1_r, b1_r, c1_r, a2_r, b2_r, c2_r, a3_r, b3_r, c3_r;
  logic signed [32:0] da1_r, db1_r;
  logic signed [PW-1:0] pac2_r, pas2_r, pbc2_r, pbs2_r;
  coord_t             a3_nxt, b3_nxt;

  // valid and skip travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  // stage 1: offsets from the center
  always_ff @(posedge clk) begin
    a1_r  <= a_i;
    b1_r  <= b_i;
    c1_r  <= c_i;
    da1_r <= $signed({a_i[31], a_i}) - $signed({ca_i[31], ca_i});
    db1_r <= $signed({b_i[31], b_i}) - $signed({cb_i[31], cb_i});
  end

  // stage 2: trig products
  always_ff @(posedge clk) begin
    a2_r   <= a1_r;
    b2_r   <= b1_r;
    c2_r   <= c1_r;
    pac2_r <= PW'(da1_r) * PW'(cs_i);
    pas2_r <= PW'(da1_r) * PW'(sn_i);
    pbc2_r <= PW'(db1_r) * PW'(cs_i);
    pbs2_r <= PW'(db1_r) * PW'(sn_i);
  end

  // stage 3: round each product, add center, saturate
  always_comb begin
    logic signed [PW-1:0] rac, ras, rbc, rbs;
    rac = (pac2_r + RND) >>> TRIG_FRAC;
    ras = (pas2_r + RND) >>> TRIG_FRAC;
    rbc = (pbc2_r + RND) >>> TRIG_FRAC;
    rbs = (pbs2_r + RND) >>> TRIG_FRAC;
    if (ctl2_r.skip) begin
      a3_nxt = a2_r;
      b3_nxt = b2_r;
    end else begin
      a3_nxt = sat32(68'(ca_i) + 68'(rac) - 68'(rbs));
      b3_nxt = sat32(68'(cb_i) + 68'(ras) + 68'(rbc));
    end
  end

  always_ff @(posedge clk) begin
    a3_r <= a3_nxt;
    b3_r <= b3_nxt;
    c3_r <= c2_r;
  end

  assign ctl_o = ctl3_r;
  assign a_o   = a3_r;
  assign b_o   = b3_r;
  assign c_o   = c3_r;

endmodule

/* sv/point_3d_affine_transform_top.sv */
// ----------------------------------------------------------------------------
// point_3d_affine_transform_top
// Throughput: one point per cycle while busy is low, set by the three plane
// rotation pipelines. After reset and after every configuration write, busy
// stays high while the trig sequencer runs: per angle one load, one modulo,
// one fold and 24 CORDIC steps. Reset selects move mode, zeroes the centers,
// coefficients and valid flags and restarts the trig sequencer; the data
// registers are not reset. Results cannot be held off.
// ----------------------------------------------------------------------------
module point_3d_affine_transform_top #(
  parameter int FRAC_BITS      = p3at_pkg::FRAC_BITS_DEF,
  parameter int NEAR_TOLERANCE = p3at_pkg::NEAR_TOL_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  p3at_pkg::coord_t in_x,
  input  p3at_pkg::coord_t in_y,
  input  p3at_pkg::coord_t in_z,
  output logic             out_valid,
  output p3at_pkg::coord_t out_x,
  output p3at_pkg::coord_t out_y,
  output p3at_pkg::coord_t out_z,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [31:0]      cfg_wdata
);
  import p3at_pkg::*;

  localparam int ANGW = 32 + ANG_FRAC - FRAC_BITS;
  localparam int DLY  = 6;
  localparam int LAT  = 11;
  localparam logic signed [32:0] TOL = 33'(NEAR_TOLERANCE);
  localparam logic signed [67:0] SC_RND = 68'sd1 <<< (FRAC_BITS - 1);
  // a full turn is 45 * 2^27, so the modulo only needs the bits above 27
  localparam int          MOD_SHIFT = 27;
  localparam logic [20:0] MOD_DIV   = 21'd45;
  localparam logic [21:0] MOD_RECIP = 22'd2982617;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_LOAD = 5'b00010,
    T_MOD  = 5'b00100,
    T_FOLD = 5'b01000,
    T_CORD = 5'b10000
  } tr_state_t;

  logic [1:0] mode_r;
  coord_t     center_r [3];
  coord_t     coeff_r  [3];

  tr_state_t          tr_state_r, tr_state_nxt;
  logic [1:0]         tr_sel_r, tr_sel_nxt;
  logic [ANGW-1:0]    tr_num_r, tr_num_nxt;
  logic               tr_neg_r, tr_neg_nxt;
  logic [32:0]        tr_rem_r, tr_rem_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic               tr_flip_r, tr_flip_nxt;
  logic [4:0]         tr_i_r, tr_i_nxt;
  logic               tr_store;
  trig_t              sn_r [3];
  trig_t              cs_r [3];

  logic      acc;
  p3at_ctl_t e_ctl_r;
  coord_t    e_p_r [3];
  logic      near;

  p3at_ctl_t ctl0, ctl1, ctl2;
  coord_t    a0, b0, c0, a1, b1, c1, a2, b2, c2;

  logic signed [32:0] m1_sum_r [3];
  logic signed [32:0] m1_d_r   [3];
  logic signed [32:0] m2_sum_r [3];
  logic signed [64:0] m2_prod_r [3];
  coord_t             m3_r [3];
  coord_t             m3_nxt [3];
  coord_t             md_r [DLY][3];
  logic               ms_sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MOVE;
      for (int i = 0; i < 3; i++) begin
        center_r[i] <= '0;
        coeff_r[i]  <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:     mode_r      <= cfg_wdata[1:0];
        REG_CENTER_X: center_r[0] <= cfg_wdata;
        REG_CENTER_Y: center_r[1] <= cfg_wdata;
        REG_CENTER_Z: center_r[2] <= cfg_wdata;
        REG_COEFF_X:  coeff_r[0]  <= cfg_wdata;
        REG_COEFF_Y:  coeff_r[1]  <= cfg_wdata;
        REG_COEFF_Z:  coeff_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // trig sequencer: modulo by reciprocal multiply, fold, then cordic
  always_comb begin
    logic signed [ANGW-1:0] ang_w;
    logic [20:0]            h;
    logic [42:0]            qp;
    logic [20:0]            hr;
    logic [33:0]            z0;
    logic signed [34:0]     zs;
    logic signed [33:0]     shx, shy;
    tr_state_nxt = tr_state_r;
    tr_sel_nxt   = tr_sel_r;
    tr_num_nxt   = tr_num_r;
    tr_neg_nxt   = tr_neg_r;
    tr_rem_nxt   = tr_rem_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    cz_nxt       = cz_r;
    tr_flip_nxt  = tr_flip_r;
    tr_i_nxt     = tr_i_r;
    tr_store     = 1'b0;
    ang_w = ANGW'(coeff_r[tr_sel_r]) <<< (ANG_FRAC - FRAC_BITS);
    // upper bits modulo 45, quotient is exact for 21-bit values
    h     = 21'(tr_num_r >> MOD_SHIFT);
    qp    = 43'(h) * 43'(MOD_RECIP);
    hr    = h - 21'(qp[42:MOD_SHIFT]) * MOD_DIV;
    z0    = (tr_neg_r && (tr_rem_r != '0)) ? (FULL_TURN - {1'b0, tr_rem_r})
                                           : {1'b0, tr_rem_r};
    zs    = $signed({1'b0, z0});
    shx   = cx_r >>> tr_i_r;
    shy   = cy_r >>> tr_i_r;
    case (tr_state_r)
      T_IDLE: ;
      T_LOAD: begin
        tr_neg_nxt   = ang_w[ANGW-1];
        tr_num_nxt   = ang_w[ANGW-1] ? ANGW'(-ang_w) : ANGW'(ang_w);
        tr_rem_nxt   = '0;
        tr_state_nxt = T_MOD;
      end
      T_MOD: begin
        tr_rem_nxt   = {hr[5:0], tr_num_r[MOD_SHIFT-1:0]};
        tr_state_nxt = T_FOLD;
      end
      T_FOLD: begin
        if (z0 >= HALF_TURN) begin
          zs = zs - $signed({1'b0, FULL_TURN});
        end
        tr_flip_nxt = 1'b0;
        if (zs > $signed({1'b0, QUARTER_TURN})) begin
          zs          = zs - $signed({1'b0, HALF_TURN});
          tr_flip_nxt = 1'b1;
        end else if (zs < -$signed({1'b0, QUARTER_TURN})) begin
          zs          = zs + $signed({1'b0, HALF_TURN});
          tr_flip_nxt = 1'b1;
        end
        cz_nxt       = zs[33:0];
        cx_nxt       = CORDIC_GAIN_INV;
        cy_nxt       = '0;
        tr_i_nxt     = '0;
        tr_state_nxt = T_CORD;
      end
      T_CORD: begin
        if (!cz_r[33]) begin
          cx_nxt = cx_r - shy;
          cy_nxt = cy_r + shx;
          cz_nxt = cz_r - atan_deg(tr_i_r);
        end else begin
          cx_nxt = cx_r + shy;
          cy_nxt = cy_r - shx;
          cz_nxt = cz_r + atan_deg(tr_i_r);
        end
        tr_i_nxt = tr_i_r + 1'b1;
        if (tr_i_r == 5'(CORDIC_STEPS - 1)) begin
          tr_store = 1'b1;
          if (tr_sel_r == 2'd2) begin
            tr_state_nxt = T_IDLE;
          end else begin
            tr_sel_nxt   = tr_sel_r + 1'b1;
            tr_state_nxt = T_LOAD;
          end
        end
      end
      default: tr_state_nxt = T_IDLE;
    endcase
    // any configuration write restarts the sequence
    if (cfg_we) begin
      tr_state_nxt = T_LOAD;
      tr_sel_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tr_state_r <= T_LOAD;
      tr_sel_r   <= '0;
      tr_i_r     <= '0;
    end else begin
      tr_state_r <= tr_state_nxt;
      tr_sel_r   <= tr_sel_nxt;
      tr_i_r     <= tr_i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tr_num_r  <= tr_num_nxt;
    tr_neg_r  <= tr_neg_nxt;
    tr_rem_r  <= tr_rem_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cz_r      <= cz_nxt;
    tr_flip_r <= tr_flip_nxt;
    if (tr_store) begin
      cs_r[tr_sel_r] <= tr_flip_r ? 33'(-cx_nxt) : 33'(cx_nxt);
      sn_r[tr_sel_r] <= tr_flip_r ? 33'(-cy_nxt) : 33'(cy_nxt);
    end
  end

  assign busy = (tr_state_r != T_IDLE);
  assign acc  = start && !busy;

  // near-center test on the incoming point
  always_comb begin
    logic signed [32:0] d;
    near = 1'b1;
    d = $signed({in_x[31], in_x}) - $signed({center_r[0][31], center_r[0]});
    if (!((d < TOL) && (d > -TOL))) near = 1'b0;
    d = $signed({in_y[31], in_y}) - $signed({center_r[1][31], center_r[1]});
    if (!((d < TOL) && (d > -TOL))) near = 1'b0;
    d = $signed({in_z[31], in_z}) - $signed({center_r[2][31], center_r[2]});
    if (!((d < TOL) && (d > -TOL))) near = 1'b0;
  end

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_ctl_r <= '0;
    end else begin
      e_ctl_r.valid <= acc;
      e_ctl_r.skip  <= near || (mode_r != MODE_ROTATE);
    end
  end

  always_ff @(posedge clk) begin
    e_p_r[0] <= in_x;
    e_p_r[1] <= in_y;
    e_p_r[2] <= in_z;
  end

  // yz plane
  p3at_plane u_plane_yz (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (e_ctl_r),
    .a_i   (e_p_r[1]),
    .b_i   (e_p_r[2]),
    .c_i   (e_p_r[0]),
    .ca_i  (center_r[1]),
    .cb_i  (center_r[2]),
    .sn_i  (sn_r[0]),
    .cs_i  (cs_r[0]),
    .ctl_o (ctl0),
    .a_o   (a0),
    .b_o   (b0),
    .c_o   (c0)
  );

  // xz plane
  p3at_plane u_plane_zx (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl0),
    .a_i   (b0),
    .b_i   (c0),
    .c_i   (a0),
    .ca_i  (center_r[2]),
    .cb_i  (center_r[0]),
    .sn_i  (sn_r[1]),
    .cs_i  (cs_r[1]),
    .ctl_o (ctl1),
    .a_o   (a1),
    .b_o   (b1),
    .c_o   (c1)
  );

  // xy plane
  p3at_plane u_plane_xy (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl1),
    .a_i   (b1),
    .b_i   (c1),
    .c_i   (a1),
    .ca_i  (center_r[0]),
    .cb_i  (center_r[1]),
    .sn_i  (sn_r[2]),
    .cs_i  (cs_r[2]),
    .ctl_o (ctl2),
    .a_o   (a2),
    .b_o   (b2),
    .c_o   (c2)
  );

  // move and scale lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mode_r == MODE_MOVE) begin
        m3_nxt[i] = sat32(68'(m2_sum_r[i]));
      end else begin
        m3_nxt[i] = sat32(68'(center_r[i]) + ((68'(m2_prod_r[i]) + SC_RND) >>> FRAC_BITS));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m1_sum_r[i]  <= $signed({e_p_r[i][31], e_p_r[i]})
                    + $signed({coeff_r[i][31], coeff_r[i]});
      m1_d_r[i]    <= $signed({e_p_r[i][31], e_p_r[i]})
                    - $signed({center_r[i][31], center_r[i]});
      m2_sum_r[i]  <= m1_sum_r[i];
      m2_prod_r[i] <= 65'(coeff_r[i]) * 65'(m1_d_r[i]);
      m3_r[i]      <= m3_nxt[i];
      md_r[0][i]   <= m3_r[i];
      for (int s = 1; s < DLY; s++) begin
        md_r[s][i] <= md_r[s-1][i];
      end
    end
  end

  // output register
  assign ms_sel = (mode_r == MODE_MOVE) || (mode_r == MODE_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl2.valid;
    end
  end

  // the xy plane carries x in a, y in b and z in c
  always_ff @(posedge clk) begin
    out_x <= ms_sel ? md_r[DLY-1][0] : a2;
    out_y <= ms_sel ? md_r[DLY-1][1] : b2;
    out_z <= ms_sel ? md_r[DLY-1][2] : c2;
  end

  // every configuration write raises busy to hold off new transactions
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("busy not raised after configuration write");

  // every accepted transaction gives its result after the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("result strobe missing after accepted transaction");

  // cordic step counter stays inside the table
  a_cord_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (tr_state_r == T_CORD) |-> (tr_i_r < 5'(CORDIC_STEPS)))
    else $error("cordic step index out of range");

endmodule

/* bench/tb_point_3d_affine_transform_top.sv */
// ----------------------------------------------------------------------------
// tb_point_3d_affine_transform_top
// Self-checking bench for the 3D point affine transform. A built-in
// fixed-point transform predictor (move, scale, CORDIC rotate) computes every
// expected point; directed cases cover extremes and corner cases, then random
// phases with fresh register settings run with random start gaps.
// ----------------------------------------------------------------------------
module tb_point_3d_affine_transform_top;
  import p3at_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    SETTLE_CYCLES  = 16;
  localparam longint DEG_FULL    = 64'sd6039797760;
  localparam longint DEG_HALF    = 64'sd3019898880;
  localparam longint DEG_QUARTER = 64'sd1509949440;
  localparam longint GAIN_INV    = 64'sd652032874;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [1:0] MODE_PASS  = 2'd3;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_x, in_y, in_z;
  logic   out_valid;
  coord_t out_x, out_y, out_z;
  logic   cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  // shadow copy of the transform registers
  logic [1:0] xf_mode;
  coord_t     xf_center [3];
  coord_t     xf_coeff [3];

  point_t expected_points[$];
  bit     idle_on;
  int     err_cnt;
  int     points_sent;
  int     points_checked;
  int     cfg_writes;
  int     stall_cycles;

  longint atan_steps [CORDIC_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  point_3d_affine_transform_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // sine and cosine of a Q16.16 angle in degrees, 30 fraction bits
  function automatic void sin_cos_deg(input coord_t ang, output longint sn,
                                      output longint cs);
    longint z, x, y, t;
    bit     flip;
    z = (longint'(ang) * 256) % DEG_FULL;
    flip = 1'b0;
    x = GAIN_INV;
    y = 0;
    if (z < 0) z += DEG_FULL;
    if (z >= DEG_HALF) z -= DEG_FULL;
    if (z > DEG_QUARTER) begin
      z -= DEG_HALF;
      flip = 1'b1;
    end else if (z < -DEG_QUARTER) begin
      z += DEG_HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_steps[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_steps[i];
      end
      x = t;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint trig_mul(input longint d, input longint k);
    return (d * k + (64'sd1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
  endfunction

  // rotate (a, b) about (ca, cb)
  function automatic void plane_turn(inout longint a, inout longint b,
                                     input longint ca, input longint cb,
                                     input coord_t ang);
    longint sn, cs, da, db;
    sin_cos_deg(ang, sn, cs);
    da = a - ca;
    db = b - cb;
    a = clamp32(ca + trig_mul(da, cs) - trig_mul(db, sn));
    b = clamp32(cb + trig_mul(da, sn) + trig_mul(db, cs));
  endfunction

  function automatic point_t transform_point(input point_t pt);
    longint p [3];
    longint c [3];
    longint k [3];
    bit     at_center;
    point_t r;
    p[0] = pt.x;
    p[1] = pt.y;
    p[2] = pt.z;
    for (int i = 0; i < 3; i++) begin
      c[i] = xf_center[i];
      k[i] = xf_coeff[i];
    end
    case (xf_mode)
      MODE_MOVE: begin
        for (int i = 0; i < 3; i++) p[i] = clamp32(p[i] + k[i]);
      end
      MODE_SCALE: begin
        for (int i = 0; i < 3; i++)
          p[i] = clamp32(c[i] + ((k[i] * (p[i] - c[i]) + 64'sd32768) >>> 16));
      end
      MODE_ROTATE: begin
        at_center = 1'b1;
        for (int i = 0; i < 3; i++)
          if (p[i] != c[i]) at_center = 1'b0;
        if (!at_center) begin
          plane_turn(p[1], p[2], c[1], c[2], xf_coeff[0]);
          plane_turn(p[2], p[0], c[2], c[0], xf_coeff[1]);
          plane_turn(p[0], p[1], c[0], c[1], xf_coeff[2]);
        end
      end
      default: ;
    endcase
    r.x = p[0][31:0];
    r.y = p[1][31:0];
    r.z = p[2][31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(input string what, input coord_t got,
                                 input coord_t want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // one register write, cfg_we is lowered by end_config
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      REG_MODE:     xf_mode      = val[1:0];
      REG_CENTER_X: xf_center[0] = val;
      REG_CENTER_Y: xf_center[1] = val;
      REG_CENTER_Z: xf_center[2] = val;
      REG_COEFF_X:  xf_coeff[0]  = val;
      REG_COEFF_Y:  xf_coeff[1]  = val;
      REG_COEFF_Z:  xf_coeff[2]  = val;
      default: ;
    endcase
  endtask

  task automatic end_config();
    cfg_we <= 1'b0;
  endtask

  // full register setting; mode upper bits carry random junk
  task automatic set_transform(input logic [1:0] mode, input coord_t cx,
                               input coord_t cy, input coord_t cz, input coord_t kx,
                               input coord_t ky, input coord_t kz);
    write_reg(REG_MODE, {30'($urandom() >> 2), mode});
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_COEFF_X, kx);
    write_reg(REG_COEFF_Y, ky);
    write_reg(REG_COEFF_Z, kz);
    end_config();
  endtask

  // one start transaction
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    int     gap;
    point_t pt;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_x  <= x;
    in_y  <= y;
    in_z  <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    pt.x = x;
    pt.y = y;
    pt.z = z;
    expected_points.push_back(transform_point(pt));
    points_sent++;
  endtask

  // stop sending and let the pipeline empty
  task automatic drain();
    start <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(input coord_t around);
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      3:    return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
      4:    return around;
      default: return around + $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_move();
    set_transform(MODE_MOVE, 0, 0, 0, 32'sh0001_0000, -1, 32'sh7fffffff);
    send_point(0, 0, 0);
    send_point(32'sh7fffffff, 32'sh80000000, 1);
    send_point(32'sh80000000, 32'sh7fffffff, -1);
    drain();
    set_transform(MODE_MOVE, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_point(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    drain();
  endtask

  task automatic test_scale();
    set_transform(MODE_SCALE, 32'sh0001_0000, -32'sh0005_0000, 32'sh80000000,
                  32'sh0002_0000, 32'sh80000000, 32'sh7fffffff);
    send_point(32'sh0001_8000, 32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh7fffffff, 0, 32'sh80000001);
    send_point(32'sh0001_0000, -32'sh0005_0001, 0);
    drain();
  endtask

  task automatic test_rotate();
    set_transform(MODE_ROTATE, 0, 0, 0, 32'sh005a_0000, -32'sh00b4_0000, 32'sh7fffffff);
    send_point(0, 0, 0);
    send_point(1, 0, 0);
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    drain();
    set_transform(MODE_ROTATE, 32'sh7fffffff, 32'sh80000000, 32'sh1234_5678,
                  32'sh80000000, 32'sh0000_0001, 32'sh010e_0000);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh1234_5678);
    send_point(32'sh7fffffff, 32'sh80000001, 32'sh1234_5678);
    send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    drain();
  endtask

  task automatic test_passthrough();
    // unused register index must be ignored
    write_reg(REG_UNUSED, $urandom());
    set_transform(MODE_PASS, 32'sh1111_0000, 32'sh2222_0000, 32'sh3333_0000,
                  32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000);
    send_point(32'sh7fffffff, 32'sh80000000, 0);
    send_point(-1, 1, 32'sh0001_0000);
    drain();
  endtask

  task automatic test_random(input int n_points);
    logic [1:0] mode;
    coord_t     c [3];
    coord_t     k [3];
    coord_t     x, y, z;
    int         sent;
    sent = 0;
    while (sent < n_points) begin
      if (sent > n_points * 3 / 4) idle_on = 1'b0;
      mode = ($urandom_range(0, 9) == 0) ? MODE_PASS : 2'($urandom_range(0, 2));
      for (int i = 0; i < 3; i++) begin
        c[i] = rand_coord(0);
        case ($urandom_range(0, 3))
          0:       k[i] = $urandom();
          1:       k[i] = ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
          default: k[i] = $signed($urandom_range(0, 32'h0300_0000)) - 32'sh0180_0000;
        endcase
      end
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          write_reg(REG_UNUSED, $urandom());
        end else begin
          write_reg(REG_MODE, 32'(mode));
        end
      end
      set_transform(mode, c[0], c[1], c[2], k[0], k[1], k[2]);
      for (int j = $urandom_range(20, 60); j > 0 && sent < n_points; j--) begin
        // a whole point on the center hits the near-center bypass
        if ($urandom_range(0, 15) == 0) begin
          x = c[0];
          y = c[1];
          z = c[2];
        end else begin
          x = rand_coord(c[0]);
          y = rand_coord(c[1]);
          z = rand_coord(c[2]);
        end
        send_point(x, y, z);
        sent++;
      end
      drain();
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        $display("[%0t] result with no point outstanding", $realtime);
        err_cnt++;
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", stall_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_x      = '0;
    in_y      = '0;
    in_z      = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    xf_mode   = MODE_MOVE;
    for (int i = 0; i < 3; i++) begin
      xf_center[i] = '0;
      xf_coeff[i]  = '0;
    end
    idle_on        = 1'b1;
    err_cnt        = 0;
    points_sent    = 0;
    points_checked = 0;
    cfg_writes     = 0;
    stall_cycles   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: move by zero
    send_point(32'sh0123_4567, -32'sh0765_4321, 32'sh7fffffff);
    drain();
    test_move();
    test_scale();
    test_rotate();
    test_passthrough();
    test_random(450);
    drain();

    $display("covered %0d points over %0d register writes in move, scale, rotate and",
             points_sent, cfg_writes);
    $display("pass-through modes; %0d results checked, %0d mismatches",
             points_checked, err_cnt);
    if (err_cnt == 0 && expected_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
